// File: sv/blpa_pkg.sv
// Shared types, constants and operation codes of the binned load profile accumulator.
`timescale 1ns / 1ps

package blpa_pkg;

    // Default geometry and averaging limits.
    localparam int BIN_COUNT_DEF       = 72;
    localparam int BIN_WIDTH_DEF       = 500;
    localparam int TRUE_MEAN_LIMIT_DEF = 200;

    // Fixed limits of the position and count ranges.
    localparam int FULL_TURN     = 36000;
    localparam int IGNORE_MAX    = 6000;
    localparam int CAL_COUNT_MAX = 65000;
    localparam int PCT_SCALE     = 100;
    localparam int PCT_MAX       = 32767;

    // Shared divider geometry.
    localparam int DIV_W     = 32;
    localparam int DIVISOR_W = 16;
    localparam int DIV_STEPS = 2;

    // Operation codes.
    localparam logic [2:0] OP_CAL   = 3'd0;
    localparam logic [2:0] OP_LIVE  = 3'd1;
    localparam logic [2:0] OP_FAST  = 3'd2;
    localparam logic [2:0] OP_FIN   = 3'd3;
    localparam logic [2:0] OP_READ  = 3'd4;
    localparam logic [2:0] OP_CLEAR = 3'd5;

    // Configuration register indexes.
    localparam logic [2:0] CFG_MOVE_START  = 3'd0;
    localparam logic [2:0] CFG_MOVE_TARGET = 3'd1;
    localparam logic [2:0] CFG_IGNORE_LIVE = 3'd2;
    localparam logic [2:0] CFG_IGNORE_FAST = 3'd3;
    localparam logic [2:0] CFG_MIN_MOVE    = 3'd4;

    // One bin of one direction, as held in the bin memory.
    typedef struct packed {
        logic [31:0] cal_sum;
        logic [15:0] cal_count;
        logic [15:0] base;
        logic [15:0] live;
        logic [7:0]  live_count;
        logic [15:0] fast;
        logic        fast_seen;
    } t_entry;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic latch;
        logic bin_div_start;
        logic bin_capture;
        logic sw_read;
        logic sw_div_start;
        logic sw_write;
        logic sw_zero;
        logic set_bok;
        logic ent_read;
        logic ent_mul;
        logic ent_div_start;
        logic ent_write;
        logic pct_div_start;
        logic out_fire;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [2:0] op;
        logic       div_done;
        logic       sw_last;
        logic       sw_div_need;
        logic       live_div_need;
        logic       pct_need;
    } t_sts;

endpackage

// File: sv/blpa_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module blpa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: sv/blpa_div.sv
// Iterative unsigned restoring divider, DIV_STEPS quotient bits per cycle.
`timescale 1ns / 1ps

module blpa_div (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [blpa_pkg::DIV_W-1:0]     i_dividend,
    input  logic [blpa_pkg::DIVISOR_W-1:0] i_divisor,
    output logic                           o_done,
    output logic [blpa_pkg::DIV_W-1:0]     o_quotient
);
    import blpa_pkg::*;

    localparam int ITERS = DIV_W / DIV_STEPS;
    localparam int CNT_W = $clog2(ITERS + 1);

    logic [DIVISOR_W-1:0] r_divisor;
    logic [DIVISOR_W-1:0] r_rem, n_rem;
    logic [DIV_W-1:0]     r_quo, n_quo;
    logic [CNT_W-1:0]     r_cnt;
    logic                 r_run;
    logic                 r_done;

    always_comb begin
        logic [DIVISOR_W:0] tmp;
        n_rem = r_rem;
        n_quo = r_quo;
        for (int k = 0; k < DIV_STEPS; k++) begin
            tmp   = {n_rem, n_quo[DIV_W-1]};
            n_quo = {n_quo[DIV_W-2:0], 1'b0};
            if (tmp >= {1'b0, r_divisor}) begin
                tmp      = tmp - {1'b0, r_divisor};
                n_quo[0] = 1'b1;
            end
            n_rem = tmp[DIVISOR_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_run <= 1'b1;
                r_cnt <= CNT_W'(ITERS);
            end else if (r_run) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_divisor <= i_divisor;
            r_rem     <= '0;
            r_quo     <= i_dividend;
        end else if (r_run) begin
            r_rem <= n_rem;
            r_quo <= n_quo;
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

// File: sv/blpa_ctrl.sv
// Controller state machine that sequences every request through the datapath.
`timescale 1ns / 1ps

module blpa_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    output logic           o_busy,
    input  blpa_pkg::t_sts i_sts,
    output blpa_pkg::t_cmd o_cmd
);
    import blpa_pkg::*;

    localparam logic [4:0] S_CLR  = 5'd0;
    localparam logic [4:0] S_IDLE = 5'd1;
    localparam logic [4:0] S_BIN  = 5'd2;
    localparam logic [4:0] S_BINW = 5'd3;
    localparam logic [4:0] S_SWRD = 5'd4;
    localparam logic [4:0] S_SWWT = 5'd5;
    localparam logic [4:0] S_SWDV = 5'd6;
    localparam logic [4:0] S_SWWR = 5'd7;
    localparam logic [4:0] S_RD   = 5'd8;
    localparam logic [4:0] S_WT   = 5'd9;
    localparam logic [4:0] S_MUL  = 5'd10;
    localparam logic [4:0] S_UDV  = 5'd11;
    localparam logic [4:0] S_UWT  = 5'd12;
    localparam logic [4:0] S_WB   = 5'd13;
    localparam logic [4:0] S_PCT  = 5'd14;
    localparam logic [4:0] S_PWT  = 5'd15;
    localparam logic [4:0] S_OUT  = 5'd16;

    logic [4:0] r_state, n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_CLR: begin
                o_cmd.sw_write = 1'b1;
                o_cmd.sw_zero  = 1'b1;
                if (i_sts.sw_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.latch = 1'b1;
                    n_state     = S_BIN;
                end
            end
            S_BIN: begin
                o_cmd.bin_div_start = 1'b1;
                n_state             = S_BINW;
            end
            S_BINW: begin
                if (i_sts.div_done) begin
                    o_cmd.bin_capture = 1'b1;
                    if (i_sts.op == OP_FIN || i_sts.op == OP_CLEAR) begin
                        n_state = S_SWRD;
                    end else begin
                        n_state = S_RD;
                    end
                end
            end
            S_SWRD: begin
                o_cmd.sw_read = 1'b1;
                n_state       = S_SWWT;
            end
            S_SWWT: begin
                if (i_sts.sw_div_need) begin
                    o_cmd.sw_div_start = 1'b1;
                    n_state            = S_SWDV;
                end else begin
                    n_state = S_SWWR;
                end
            end
            S_SWDV: begin
                if (i_sts.div_done) begin
                    n_state = S_SWWR;
                end
            end
            S_SWWR: begin
                o_cmd.sw_write = 1'b1;
                if (i_sts.sw_last) begin
                    o_cmd.set_bok = (i_sts.op == OP_FIN);
                    n_state       = S_RD;
                end else begin
                    n_state = S_SWRD;
                end
            end
            S_RD: begin
                o_cmd.ent_read = 1'b1;
                n_state        = S_WT;
            end
            S_WT: begin
                n_state = S_MUL;
            end
            S_MUL: begin
                o_cmd.ent_mul = 1'b1;
                n_state       = i_sts.live_div_need ? S_UDV : S_WB;
            end
            S_UDV: begin
                o_cmd.ent_div_start = 1'b1;
                n_state             = S_UWT;
            end
            S_UWT: begin
                if (i_sts.div_done) begin
                    n_state = S_WB;
                end
            end
            S_WB: begin
                o_cmd.ent_write = 1'b1;
                n_state         = S_PCT;
            end
            S_PCT: begin
                if (i_sts.pct_need) begin
                    o_cmd.pct_div_start = 1'b1;
                    n_state             = S_PWT;
                end else begin
                    n_state = S_OUT;
                end
            end
            S_PWT: begin
                if (i_sts.div_done) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                o_cmd.out_fire = 1'b1;
                n_state        = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

// File: sv/blpa_dp.sv
// Datapath: configuration, request registers, bin memory, divider and result registers.
`timescale 1ns / 1ps

module blpa_dp #(
    parameter int BIN_COUNT       = blpa_pkg::BIN_COUNT_DEF,
    parameter int BIN_WIDTH       = blpa_pkg::BIN_WIDTH_DEF,
    parameter int TRUE_MEAN_LIMIT = blpa_pkg::TRUE_MEAN_LIMIT_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  blpa_pkg::t_cmd        i_cmd,
    output blpa_pkg::t_sts        o_sts,
    input  logic                  i_cfg_we,
    input  logic [2:0]            i_cfg_index,
    input  logic [15:0]           i_cfg_wdata,
    input  logic [2:0]            i_operation,
    input  logic signed [17:0]    i_position,
    input  logic [15:0]           i_current_cw,
    input  logic [15:0]           i_current_ccw,
    input  logic                  i_direction,
    input  logic [6:0]            i_bin_index,
    output logic                  o_valid,
    output logic                  o_accepted,
    output logic [6:0]            o_bin_used,
    output logic [15:0]           o_live_mean,
    output logic [15:0]           o_fast_mean,
    output logic [15:0]           o_baseline,
    output logic signed [15:0]    o_delta_pct,
    output logic                  o_baseline_valid
);
    import blpa_pkg::*;

    localparam int DEPTH = 2 * BIN_COUNT;
    localparam int AW    = $clog2(DEPTH);
    localparam int BW    = $clog2(BIN_COUNT);
    localparam int EW    = $bits(t_entry);

    // Configuration registers.
    logic [15:0] r_move_start, r_move_target, r_min_move;
    logic [12:0] r_ignore_live, r_ignore_fast;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_move_start  <= '0;
            r_move_target <= '0;
            r_ignore_live <= 13'd3000;
            r_ignore_fast <= '0;
            r_min_move    <= 16'd500;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_MOVE_START:  r_move_start  <= i_cfg_wdata;
                CFG_MOVE_TARGET: r_move_target <= i_cfg_wdata;
                CFG_IGNORE_LIVE: r_ignore_live <= i_cfg_wdata[12:0];
                CFG_IGNORE_FAST: r_ignore_fast <= i_cfg_wdata[12:0];
                CFG_MIN_MOVE:    r_min_move    <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // Request registers.
    logic [2:0]         r_op;
    logic signed [17:0] r_pos;
    logic [15:0]        r_cw, r_ccw;
    logic               r_dir;
    logic [6:0]         r_bidx;

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_op   <= i_operation;
            r_pos  <= i_position;
            r_cw   <= i_current_cw;
            r_ccw  <= i_current_ccw;
            r_dir  <= i_direction;
            r_bidx <= i_bin_index;
        end
    end

    // Shared divider and its operand selection.
    logic             div_start, div_done;
    logic [DIV_W-1:0] div_dividend, div_q;
    logic [15:0]      div_divisor;

    t_entry           ent;
    logic [15:0]      pos_clamp;
    logic [23:0]      r_prod;
    logic [15:0]      r_mv;
    logic [15:0]      live_divisor;
    logic [15:0]      r_rlive, r_rfast, r_rbase;
    logic             r_bok;
    logic [15:0]      pct_mag;

    assign div_start = i_cmd.bin_div_start | i_cmd.sw_div_start
                     | i_cmd.ent_div_start | i_cmd.pct_div_start;

    always_comb begin
        div_dividend = DIV_W'(pos_clamp);
        div_divisor  = 16'(BIN_WIDTH);
        if (i_cmd.sw_div_start) begin
            div_dividend = ent.cal_sum;
            div_divisor  = ent.cal_count;
        end else if (i_cmd.ent_div_start) begin
            div_dividend = DIV_W'(r_prod) + DIV_W'(r_mv);
            div_divisor  = live_divisor;
        end else if (i_cmd.pct_div_start) begin
            div_dividend = DIV_W'(pct_mag) * DIV_W'(PCT_SCALE);
            div_divisor  = r_rbase;
        end
    end

    blpa_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_quotient (div_q)
    );

    // Position clamp and sample windows.
    logic signed [19:0] pos_s, ig_s, lo_s, hi_s, full_s;
    logic [12:0]        ig_live, ig_fast, ig;
    logic [15:0]        mn, mx, span;
    logic               mdir, move_ok, win_ok, cal_ok;
    logic [15:0]        cal_mv, mov_mv0, mov_mv;

    assign pos_s  = 20'(r_pos);
    assign full_s = signed'(20'(FULL_TURN));

    always_comb begin
        if (r_pos < 0) begin
            pos_clamp = '0;
        end else if (pos_s > full_s) begin
            pos_clamp = 16'(FULL_TURN);
        end else begin
            pos_clamp = r_pos[15:0];
        end
    end

    assign ig_live = (r_ignore_live > 13'(IGNORE_MAX)) ? 13'(IGNORE_MAX) : r_ignore_live;
    assign ig_fast = (r_ignore_fast > 13'(IGNORE_MAX)) ? 13'(IGNORE_MAX) : r_ignore_fast;
    assign ig      = (r_op == OP_FAST) ? ig_fast : ig_live;
    assign ig_s    = signed'({7'd0, ig});

    assign mdir    = (r_move_target < r_move_start);
    assign mn      = mdir ? r_move_target : r_move_start;
    assign mx      = mdir ? r_move_start : r_move_target;
    assign span    = mx - mn;
    assign move_ok = (r_move_start != r_move_target) && (span >= r_min_move);
    assign lo_s    = signed'({4'd0, mn}) + ig_s;
    assign hi_s    = signed'({4'd0, mx}) - ig_s;
    assign win_ok  = move_ok && (lo_s <= hi_s) && (pos_s >= lo_s) && (pos_s <= hi_s);
    assign cal_ok  = (pos_s >= ig_s) && (pos_s <= full_s - ig_s);

    assign cal_mv  = r_dir ? r_ccw : r_cw;
    assign mov_mv0 = mdir ? r_ccw : r_cw;
    assign mov_mv  = (mov_mv0 != 16'd0) ? mov_mv0 : ((r_cw >= r_ccw) ? r_cw : r_ccw);

    // Decode of the addressed entry, taken when the bin quotient is ready.
    logic [BW-1:0] samp_bin;
    logic [AW-1:0] r_addr;
    logic          r_acc, r_inrange;
    logic [6:0]    r_bused;

    assign samp_bin = (div_q > DIV_W'(BIN_COUNT - 1)) ? BW'(BIN_COUNT - 1) : div_q[BW-1:0];

    always_ff @(posedge i_clk) begin
        if (i_cmd.bin_capture) begin
            case (r_op) inside
                OP_CAL: begin
                    r_acc     <= cal_ok && (cal_mv != 16'd0);
                    r_mv      <= cal_mv;
                    r_inrange <= 1'b1;
                    r_bused   <= 7'(16'(samp_bin));
                    r_addr    <= AW'(r_dir ? BIN_COUNT : 0) + AW'(samp_bin);
                end
                OP_LIVE, OP_FAST: begin
                    r_acc     <= win_ok && (mov_mv != 16'd0);
                    r_mv      <= mov_mv;
                    r_inrange <= 1'b1;
                    r_bused   <= 7'(16'(samp_bin));
                    r_addr    <= AW'(mdir ? BIN_COUNT : 0) + AW'(samp_bin);
                end
                default: begin
                    r_acc     <= 1'b0;
                    r_mv      <= '0;
                    r_bused   <= r_bidx;
                    if (16'(r_bidx) < 16'(BIN_COUNT)) begin
                        r_inrange <= 1'b1;
                        r_addr    <= AW'(r_dir ? BIN_COUNT : 0) + AW'(r_bidx);
                    end else begin
                        r_inrange <= 1'b0;
                        r_addr    <= '0;
                    end
                end
            endcase
        end
    end

    // Sweep pointer over every entry of both directions.
    logic [AW-1:0] r_ptr;
    logic          sw_last;

    assign sw_last = (r_ptr == AW'(DEPTH - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptr <= '0;
        end else if (i_cmd.sw_write) begin
            r_ptr <= sw_last ? '0 : r_ptr + 1'b1;
        end
    end

    // Bin memory.
    logic          ram_we, ram_re;
    logic [AW-1:0] ram_waddr, ram_raddr;
    t_entry        sw_new, ent_new;
    logic [EW-1:0] ram_wdata, ram_rdata;

    assign ent = t_entry'(ram_rdata);

    always_comb begin
        sw_new = ent;
        if (i_cmd.sw_zero) begin
            sw_new = '0;
        end else if (r_op == OP_FIN) begin
            sw_new.base      = (ent.cal_count != 16'd0) ? div_q[15:0] : 16'd0;
            sw_new.cal_sum   = '0;
            sw_new.cal_count = '0;
        end else begin
            sw_new.live       = '0;
            sw_new.live_count = '0;
            sw_new.fast       = '0;
            sw_new.fast_seen  = 1'b0;
        end
    end

    // Entry update for an accepted sample.
    logic        lc_low;
    logic [16:0] fast_sum;

    assign lc_low       = (ent.live_count < 8'(TRUE_MEAN_LIMIT));
    assign live_divisor = lc_low ? (16'(ent.live_count) + 16'd1) : 16'(TRUE_MEAN_LIMIT);
    assign fast_sum     = {1'b0, ent.fast} + {1'b0, r_mv} + 17'd1;

    always_ff @(posedge i_clk) begin
        if (i_cmd.ent_mul) begin
            r_prod <= ent.live * (lc_low ? ent.live_count : 8'(TRUE_MEAN_LIMIT - 1));
        end
    end

    always_comb begin
        ent_new = ent;
        if (r_acc) begin
            case (r_op)
                OP_CAL: begin
                    ent_new.cal_sum = ent.cal_sum + 32'(r_mv);
                    if (ent.cal_count < 16'(CAL_COUNT_MAX)) begin
                        ent_new.cal_count = ent.cal_count + 16'd1;
                    end
                end
                OP_LIVE: begin
                    ent_new.live = div_q[15:0];
                    if (lc_low) begin
                        ent_new.live_count = ent.live_count + 8'd1;
                    end
                end
                default: begin
                    ent_new.fast      = ent.fast_seen ? fast_sum[16:1] : r_mv;
                    ent_new.fast_seen = 1'b1;
                end
            endcase
        end
    end

    assign ram_we    = i_cmd.sw_write | (i_cmd.ent_write & r_acc);
    assign ram_waddr = i_cmd.sw_write ? r_ptr : r_addr;
    assign ram_wdata = i_cmd.sw_write ? EW'(sw_new) : EW'(ent_new);
    assign ram_re    = i_cmd.sw_read | i_cmd.ent_read;
    assign ram_raddr = i_cmd.sw_read ? r_ptr : r_addr;

    blpa_ram #(
        .WIDTH (EW),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Baseline valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bok <= 1'b0;
        end else if (i_cmd.set_bok) begin
            r_bok <= 1'b1;
        end
    end

    // Result values of the addressed bin after the update.
    always_ff @(posedge i_clk) begin
        if (i_cmd.ent_write) begin
            if (r_inrange) begin
                r_rlive <= ent_new.live;
                r_rfast <= ent_new.fast;
                r_rbase <= r_bok ? ent_new.base : 16'd0;
            end else begin
                r_rlive <= '0;
                r_rfast <= '0;
                r_rbase <= '0;
            end
        end
    end

    logic        pct_need, pct_neg;
    logic [15:0] pct_val;

    assign pct_need = r_bok && (r_rbase != 16'd0) && (r_rlive != 16'd0);
    assign pct_neg  = (r_rlive < r_rbase);
    assign pct_mag  = pct_neg ? (r_rbase - r_rlive) : (r_rlive - r_rbase);

    always_comb begin
        if (!pct_need) begin
            pct_val = '0;
        end else if (pct_neg) begin
            pct_val = 16'd0 - div_q[15:0];
        end else if (div_q > DIV_W'(PCT_MAX)) begin
            pct_val = 16'(PCT_MAX);
        end else begin
            pct_val = div_q[15:0];
        end
    end

    // Output registers; the strobe marks one cycle per result.
    logic r_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_cmd.out_fire;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_fire) begin
            o_accepted       <= r_acc;
            o_bin_used       <= r_bused;
            o_live_mean      <= r_rlive;
            o_fast_mean      <= r_rfast;
            o_baseline       <= r_rbase;
            o_delta_pct      <= signed'(pct_val);
            o_baseline_valid <= r_bok;
        end
    end

    assign o_valid = r_valid;

    assign o_sts.op            = r_op;
    assign o_sts.div_done      = div_done;
    assign o_sts.sw_last       = sw_last;
    assign o_sts.sw_div_need   = (r_op == OP_FIN) && (ent.cal_count != 16'd0);
    assign o_sts.live_div_need = r_acc && (r_op == OP_LIVE);
    assign o_sts.pct_need      = pct_need;

endmodule

// File: sv/binned_load_profile_accumulator_unit.sv
// Top level of the binned load profile accumulator: controller and datapath.
`timescale 1ns / 1ps

// A request is taken at a rising edge with start high and busy low. It carries
// an operation code, a rotor position, both channel currents, a direction and
// a bin index. Each request produces exactly one result, shown on the result
// ports for a single cycle while o_valid is high; the receiver cannot stall
// it, so it must take every result in that cycle.
// Configuration is written through i_cfg_we, i_cfg_index and i_cfg_wdata. The
// user must write it only while the block is idle; the block does not enforce
// this. The bin number comes from the shared divider, at two quotient bits per
// cycle. A sample or read then takes a memory read, an optional multiply and
// divide for the live mean and an optional divide for the percent deviation.
// Finalize and clear walk all 2*BIN_COUNT entries of the bin memory, with a
// read, a wait and a write for each entry, plus one divide for each finalized
// entry with a nonzero count.
// The rate is set by the single shared divider and the bin memory with its
// single read and single write port; one request is in work at a time.
// After reset the block clears all 2*BIN_COUNT entries of the bin memory, one
// entry per cycle, and holds busy high meanwhile.
module binned_load_profile_accumulator_unit #(
    parameter int BIN_COUNT       = blpa_pkg::BIN_COUNT_DEF,
    parameter int BIN_WIDTH       = blpa_pkg::BIN_WIDTH_DEF,
    parameter int TRUE_MEAN_LIMIT = blpa_pkg::TRUE_MEAN_LIMIT_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [2:0]         i_operation,
    input  logic signed [17:0] i_position,
    input  logic [15:0]        i_current_cw,
    input  logic [15:0]        i_current_ccw,
    input  logic               i_direction,
    input  logic [6:0]         i_bin_index,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_index,
    input  logic [15:0]        i_cfg_wdata,
    output logic               o_valid,
    output logic               o_accepted,
    output logic [6:0]         o_bin_used,
    output logic [15:0]        o_live_mean,
    output logic [15:0]        o_fast_mean,
    output logic [15:0]        o_baseline,
    output logic signed [15:0] o_delta_pct,
    output logic               o_baseline_valid
);
    import blpa_pkg::*;

    // The controller sees only status, the datapath only commands.
    t_cmd cmd;
    t_sts sts;

    blpa_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .o_busy  (busy),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    blpa_dp #(
        .BIN_COUNT       (BIN_COUNT),
        .BIN_WIDTH       (BIN_WIDTH),
        .TRUE_MEAN_LIMIT (TRUE_MEAN_LIMIT)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_sts            (sts),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_wdata      (i_cfg_wdata),
        .i_operation      (i_operation),
        .i_position       (i_position),
        .i_current_cw     (i_current_cw),
        .i_current_ccw    (i_current_ccw),
        .i_direction      (i_direction),
        .i_bin_index      (i_bin_index),
        .o_valid          (o_valid),
        .o_accepted       (o_accepted),
        .o_bin_used       (o_bin_used),
        .o_live_mean      (o_live_mean),
        .o_fast_mean      (o_fast_mean),
        .o_baseline       (o_baseline),
        .o_delta_pct      (o_delta_pct),
        .o_baseline_valid (o_baseline_valid)
    );

endmodule

// File: tb/blpa_checker.sv
// Checker of the load profile accumulator: predicts every result and compares it.
`timescale 1ns / 1ps

module blpa_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    input  logic               busy,
    input  logic [2:0]         i_operation,
    input  logic signed [17:0] i_position,
    input  logic [15:0]        i_current_cw,
    input  logic [15:0]        i_current_ccw,
    input  logic               i_direction,
    input  logic [6:0]         i_bin_index,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_index,
    input  logic [15:0]        i_cfg_wdata,
    input  logic               o_valid,
    input  logic               o_accepted,
    input  logic [6:0]         o_bin_used,
    input  logic [15:0]        o_live_mean,
    input  logic [15:0]        o_fast_mean,
    input  logic [15:0]        o_baseline,
    input  logic signed [15:0] o_delta_pct,
    input  logic               o_baseline_valid,
    output int                 fail_count,
    output int                 pending
);
    import blpa_pkg::*;

    localparam int NBIN = BIN_COUNT_DEF;

    typedef struct packed {
        logic        acc;
        logic [6:0]  bin;
        logic [15:0] live;
        logic [15:0] fast;
        logic [15:0] base;
        logic [15:0] pct;
        logic        bvalid;
    } t_bin_report;

    t_bin_report report_q[$];

    logic [31:0] sum_r   [2][NBIN];
    logic [15:0] cnt_r   [2][NBIN];
    logic [15:0] base_r  [2][NBIN];
    logic        base_ok;
    logic [15:0] live_r  [2][NBIN];
    logic [7:0]  lcnt_r  [2][NBIN];
    logic [15:0] fast_r  [2][NBIN];
    logic        fseen_r [2][NBIN];

    logic [15:0] mv_start, mv_target, mv_min;
    logic [12:0] ign_live, ign_fast;

    function automatic int bin_of(int p);
        int q;
        if (p < 0) p = 0;
        if (p > FULL_TURN) p = FULL_TURN;
        q = p / BIN_WIDTH_DEF;
        if (q > NBIN - 1) q = NBIN - 1;
        return q;
    endfunction

    function automatic int ramp(logic [12:0] v);
        return (v > IGNORE_MAX) ? IGNORE_MAX : int'(v);
    endfunction

    function automatic bit in_move(int p, int ig);
        int s, t, span, lo, hi;
        s = int'(mv_start);
        t = int'(mv_target);
        span = (t > s) ? t - s : s - t;
        if (s == t || span < int'(mv_min)) return 0;
        if (t > s) begin
            lo = s + ig;
            hi = t - ig;
        end else begin
            lo = t + ig;
            hi = s - ig;
        end
        if (lo > hi) return 0;
        return (p >= lo) && (p <= hi);
    endfunction

    function automatic t_bin_report make_report(logic a, int d, int b);
        t_bin_report r;
        int lv, bs, pc;
        lv = 0;
        bs = 0;
        pc = 0;
        r.fast = 0;
        if (b < NBIN) begin
            lv = live_r[d][b];
            r.fast = fast_r[d][b];
            if (base_ok) begin
                bs = base_r[d][b];
                if (bs != 0 && lv != 0) begin
                    pc = ((lv - bs) * PCT_SCALE) / bs;
                    if (pc > PCT_MAX) pc = PCT_MAX;
                    if (pc < -32768) pc = -32768;
                end
            end
        end
        r.acc = a;
        r.bin = b[6:0];
        r.live = lv[15:0];
        r.base = bs[15:0];
        r.pct = pc[15:0];
        r.bvalid = base_ok;
        return r;
    endfunction

    // Applies one request to the shadow state and returns the report it causes.
    task automatic apply_request(output t_bin_report r);
        int p, b, ig, d;
        logic [31:0] mv, m, c, s;
        logic a;
        p = int'(i_position);
        b = bin_of(p);
        a = 0;
        case (i_operation)
            OP_CAL: begin
                ig = ramp(ign_live);
                d = i_direction;
                mv = d ? i_current_ccw : i_current_cw;
                if (p >= ig && p <= FULL_TURN - ig && mv > 0) begin
                    sum_r[d][b] = sum_r[d][b] + mv;
                    if (cnt_r[d][b] < CAL_COUNT_MAX) cnt_r[d][b] = cnt_r[d][b] + 1;
                    a = 1;
                end
                r = make_report(a, d, b);
            end
            OP_LIVE, OP_FAST: begin
                d = (mv_target < mv_start) ? 1 : 0;
                mv = d ? i_current_ccw : i_current_cw;
                ig = ramp(i_operation == OP_LIVE ? ign_live : ign_fast);
                if (mv == 0) mv = (i_current_cw >= i_current_ccw) ? i_current_cw : i_current_ccw;
                if (mv > 0 && in_move(p, ig)) begin
                    a = 1;
                    if (i_operation == OP_LIVE) begin
                        m = live_r[d][b];
                        c = lcnt_r[d][b];
                        if (c < TRUE_MEAN_LIMIT_DEF) begin
                            s = m * c + mv;
                            c = c + 1;
                            lcnt_r[d][b] = c[7:0];
                            live_r[d][b] = 16'(s / c);
                        end else begin
                            live_r[d][b] = 16'((m * (TRUE_MEAN_LIMIT_DEF - 1) + mv)
                                               / TRUE_MEAN_LIMIT_DEF);
                        end
                    end else if (!fseen_r[d][b]) begin
                        fast_r[d][b] = mv[15:0];
                        fseen_r[d][b] = 1;
                    end else begin
                        m = fast_r[d][b];
                        fast_r[d][b] = 16'((m * 50 + mv * 50 + 50) / 100);
                    end
                end
                r = make_report(a, d, b);
            end
            default: begin
                if (i_operation == OP_FIN) begin
                    for (int dd = 0; dd < 2; dd++)
                        for (int i = 0; i < NBIN; i++) begin
                            base_r[dd][i] = cnt_r[dd][i] ? 16'(sum_r[dd][i] / cnt_r[dd][i]) : 0;
                            sum_r[dd][i] = 0;
                            cnt_r[dd][i] = 0;
                        end
                    base_ok = 1;
                end else if (i_operation == OP_CLEAR) begin
                    for (int dd = 0; dd < 2; dd++)
                        for (int i = 0; i < NBIN; i++) begin
                            live_r[dd][i] = 0;
                            lcnt_r[dd][i] = 0;
                            fast_r[dd][i] = 0;
                            fseen_r[dd][i] = 0;
                        end
                end
                r = make_report(0, i_direction, i_bin_index);
            end
        endcase
    endtask

    task automatic compare_field(string nm, logic [15:0] e, logic [15:0] g);
        if (e !== g) begin
            fail_count++;
            $display("%0t: mismatch on %s: expected %0d, got %0d", $time, nm, e, g);
        end
    endtask

    always @(posedge i_clk) begin
        t_bin_report r, w;
        if (!i_rst_n) begin
            for (int dd = 0; dd < 2; dd++)
                for (int i = 0; i < NBIN; i++) begin
                    sum_r[dd][i] = 0;
                    cnt_r[dd][i] = 0;
                    base_r[dd][i] = 0;
                    live_r[dd][i] = 0;
                    lcnt_r[dd][i] = 0;
                    fast_r[dd][i] = 0;
                    fseen_r[dd][i] = 0;
                end
            base_ok = 0;
            mv_start = 0;
            mv_target = 0;
            ign_live = 3000;
            ign_fast = 0;
            mv_min = 500;
            report_q.delete();
        end else begin
            // A result leaves before the request of the same edge is entered.
            if (o_valid) begin
                if (report_q.size() == 0) begin
                    fail_count++;
                    $display("%0t: result with no request waiting, got bin %0d", $time,
                             o_bin_used);
                end else begin
                    w = report_q.pop_front();
                    compare_field("accepted", w.acc, o_accepted);
                    compare_field("bin_used", w.bin, o_bin_used);
                    compare_field("live_mean", w.live, o_live_mean);
                    compare_field("fast_mean", w.fast, o_fast_mean);
                    compare_field("baseline", w.base, o_baseline);
                    compare_field("delta_pct", w.pct, o_delta_pct);
                    compare_field("baseline_valid", w.bvalid, o_baseline_valid);
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_MOVE_START:  mv_start = i_cfg_wdata;
                    CFG_MOVE_TARGET: mv_target = i_cfg_wdata;
                    CFG_IGNORE_LIVE: ign_live = i_cfg_wdata[12:0];
                    CFG_IGNORE_FAST: ign_fast = i_cfg_wdata[12:0];
                    CFG_MIN_MOVE:    mv_min = i_cfg_wdata;
                    default: ;
                endcase
            end
            if (start && !busy) begin
                apply_request(r);
                report_q.push_back(r);
            end
        end
        pending = report_q.size();
    end

    initial begin
        fail_count = 0;
        pending = 0;
    end
endmodule

// File: tb/tb.sv
// Top of the load profile accumulator testbench: stimulus, timeout and verdict.
`timescale 1ns / 1ps

module tb;
    import blpa_pkg::*;

    // A finalize walks all 144 entries, with a divide where an entry needs one. The
    // limit covers the whole run several times over.
    localparam int CYCLE_LIMIT = 2000000;

    logic               i_clk;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    logic [2:0]         i_operation;
    logic signed [17:0] i_position;
    logic [15:0]        i_current_cw;
    logic [15:0]        i_current_ccw;
    logic               i_direction;
    logic [6:0]         i_bin_index;
    logic               i_cfg_we;
    logic [2:0]         i_cfg_index;
    logic [15:0]        i_cfg_wdata;
    logic               o_valid;
    logic               o_accepted;
    logic [6:0]         o_bin_used;
    logic [15:0]        o_live_mean;
    logic [15:0]        o_fast_mean;
    logic [15:0]        o_baseline;
    logic signed [15:0] o_delta_pct;
    logic               o_baseline_valid;
    int                 fail_count;
    int                 pending;
    int                 cycles;
    bit                 calm;

    binned_load_profile_accumulator_unit u_dut (.*);
    blpa_checker u_chk (.*);

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    // Watchdog on the cycle count.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // Presents one request and returns at the edge that takes it; start stays high
    // so that a following request can go out back to back.
    task automatic send_request(logic [2:0] op, int pos, logic [15:0] cw, logic [15:0] ccw,
                                logic dir, logic [6:0] bin);
        i_operation <= op;
        i_position <= pos[17:0];
        i_current_cw <= cw;
        i_current_ccw <= ccw;
        i_direction <= dir;
        i_bin_index <= bin;
        start <= 1'b1;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    task automatic pause_requests(int n);
        start <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    // Random gap between requests, skipped during the calm stretch.
    task automatic maybe_idle();
        if (!calm && $urandom_range(99) < 14) pause_requests($urandom_range(1, 6));
    endtask

    // Register writes go in only once every result has come back.
    task automatic write_reg(logic [2:0] idx, logic [15:0] val);
        start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0 || busy) @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic set_move(int s, int t, int igl, int igf, int mm);
        write_reg(CFG_MOVE_START, s[15:0]);
        write_reg(CFG_MOVE_TARGET, t[15:0]);
        write_reg(CFG_IGNORE_LIVE, igl[15:0]);
        write_reg(CFG_IGNORE_FAST, igf[15:0]);
        write_reg(CFG_MIN_MOVE, mm[15:0]);
    endtask

    function automatic logic [15:0] pick_current();
        int k;
        k = $urandom_range(99);
        if (k < 12) return 16'd0;
        if (k < 17) return 16'hFFFF;
        if (k < 60) return 16'($urandom_range(200, 3000));
        return 16'($urandom);
    endfunction

    // Position mostly inside the turn, sometimes far out of range on either side.
    function automatic int pick_position();
        int k;
        k = $urandom_range(99);
        if (k < 80) return $urandom_range(0, FULL_TURN);
        if (k < 90) return $signed($urandom_range(0, 36000)) - 36000;
        if (k < 95) return $urandom_range(36000, 72000);
        return $signed({$urandom} % 262144) - 131072;
    endfunction

    // One random request; sample operations dominate, walks over all bins are rare.
    task automatic random_request(int pos_lo, int pos_hi);
        int k, pos;
        logic [2:0] op;
        k = $urandom_range(999);
        if (k < 270) op = OP_CAL;
        else if (k < 560) op = OP_LIVE;
        else if (k < 800) op = OP_FAST;
        else if (k < 940) op = OP_READ;
        else if (k < 960) op = OP_FIN;
        else if (k < 975) op = OP_CLEAR;
        else op = 3'($urandom_range(6, 7));
        pos = (pos_lo < pos_hi) ? $urandom_range(pos_lo, pos_hi) : pick_position();
        send_request(op, pos, pick_current(), pick_current(), $urandom_range(1),
                     7'($urandom_range(127)));
        maybe_idle();
    endtask

    initial begin
        int s, t;
        cycles = 0;
        calm = 0;
        i_rst_n = 1'b0;
        start = 1'b0;
        i_operation = OP_READ;
        i_position = 0;
        i_current_cw = 0;
        i_current_ccw = 0;
        i_direction = 0;
        i_bin_index = 0;
        i_cfg_we = 1'b0;
        i_cfg_index = CFG_MOVE_START;
        i_cfg_wdata = 0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: window edges, clamping, zero and full currents, every operation,
        // a move of zero length, the unused codes and bins past the end.
        send_request(OP_READ, 0, 0, 0, 0, 7'd127);
        send_request(OP_CAL, -36000, 16'hFFFF, 0, 0, 0);
        send_request(OP_CAL, 3000, 16'hFFFF, 16'hFFFF, 0, 0);
        send_request(OP_CAL, 2999, 100, 100, 1, 0);
        send_request(OP_CAL, 33000, 0, 1234, 1, 0);
        send_request(OP_CAL, 33001, 500, 500, 1, 0);
        send_request(OP_CAL, 72000, 500, 500, 0, 0);
        send_request(OP_CAL, 20000, 0, 700, 0, 0);
        send_request(OP_LIVE, 20000, 1000, 1000, 0, 0);
        send_request(OP_FIN, 0, 0, 0, 0, 7'd6);
        send_request(OP_READ, 0, 0, 0, 0, 7'd71);
        send_request(3'd6, 0, 0, 0, 1, 7'd72);
        send_request(3'd7, 0, 0, 0, 0, 7'd40);
        set_move(0, FULL_TURN, 0, 0, 0);
        send_request(OP_LIVE, 0, 0, 900, 0, 0);
        send_request(OP_LIVE, FULL_TURN, 600, 0, 0, 0);
        send_request(OP_FAST, 0, 0, 0, 0, 0);
        send_request(OP_FAST, 0, 800, 0, 0, 0);
        send_request(OP_FAST, 0, 801, 0, 0, 0);
        send_request(OP_READ, 0, 0, 0, 0, 7'd0);
        send_request(OP_CLEAR, 0, 0, 0, 1, 7'd3);
        set_move(FULL_TURN, 0, 8191, 8191, 65535);
        send_request(OP_LIVE, 18000, 500, 500, 0, 0);
        send_request(OP_FAST, 18000, 500, 500, 0, 0);

        // Random phases, each under its own move and ramp settings.
        for (int ph = 0; ph < 9; ph++) begin
            case (ph)
                0: set_move(1000, 35000, 3000, 0, 500);
                1: set_move(30000, 2000, 0, 6000, 0);
                2: set_move(0, FULL_TURN, 6000, 1, 36000);
                4: set_move(5000, 5000, 100, 100, 0);
                5: set_move(10000, 10400, 0, 0, 500);
                default: begin
                    s = $urandom_range(0, 65535);
                    t = $urandom_range(0, 100) < 70 ? $urandom_range(0, FULL_TURN) : s ^ 16'hFFFF;
                    set_move(s, t, $urandom_range(0, 8191), $urandom_range(0, 8191),
                             $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 4000));
                end
            endcase
            calm = (ph == 6);
            if (ph == 3) begin
                // Many samples into one bin carry the live mean past its true-mean stage.
                set_move(0, FULL_TURN, 0, 0, 0);
                for (int n = 0; n < 260; n++) begin
                    send_request($urandom_range(99) < 85 ? OP_LIVE : OP_FAST,
                                 $urandom_range(12000, 12499), pick_current(),
                                 pick_current(), 0, 0);
                    maybe_idle();
                end
                send_request(OP_CAL, 12100, 2000, 0, 0, 0);
                send_request(OP_FIN, 0, 0, 0, 0, 7'd24);
            end else begin
                for (int n = 0; n < 125; n++) random_request(0, 0);
            end
        end

        start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule

// File: binned_load_profile_accumulator_unit.f
sv/blpa_pkg.sv
sv/blpa_ram.sv
sv/blpa_div.sv
sv/blpa_ctrl.sv
sv/blpa_dp.sv
sv/binned_load_profile_accumulator_unit.sv
tb/blpa_checker.sv
tb/tb.sv
